// ===== rtl/core/aes_block_cipher_ecb_cbc_assert.svh =====
// assertion macros for the aes block cipher
`ifndef AES_BLOCK_CIPHER_ECB_CBC_ASSERT_SVH
`define AES_BLOCK_CIPHER_ECB_CBC_ASSERT_SVH
`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define AES_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("aes assertion failed");
// condition must never be seen out of reset
`define AES_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("aes forbidden condition seen");
`else
`define AES_ASSERT(label, clk, rst_n, prop)
`define AES_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/aes_pkg.sv =====
// shared types, tables and field arithmetic for the aes block cipher
package aes_pkg;

    localparam int ROW_AW = 4;
    localparam int ROWS   = 15;

    // configuration register indexes
    localparam logic [3:0] REG_KEY_0  = 4'd0;
    localparam logic [3:0] REG_KEY_1  = 4'd1;
    localparam logic [3:0] REG_KEY_2  = 4'd2;
    localparam logic [3:0] REG_KEY_3  = 4'd3;
    localparam logic [3:0] REG_IV_HI  = 4'd4;
    localparam logic [3:0] REG_IV_LO  = 4'd5;
    localparam logic [3:0] REG_KEYLEN = 4'd6;
    localparam logic [3:0] REG_MODE   = 4'd7;

    // key length codes
    localparam logic [1:0] KEYLEN_128 = 2'd0;
    localparam logic [1:0] KEYLEN_192 = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_KEYRD,
        ST_INIT,
        ST_ROUND,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              en;
        logic [ROW_AW-1:0] addr;
        logic [127:0]      data;
    } ram_wr_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6A,8'hD5,8'h30,8'h36,8'hA5,8'h38,8'hBF,8'h40,8'hA3,8'h9E,8'h81,8'hF3,8'hD7,8'hFB,
        8'h7C,8'hE3,8'h39,8'h82,8'h9B,8'h2F,8'hFF,8'h87,8'h34,8'h8E,8'h43,8'h44,8'hC4,8'hDE,8'hE9,8'hCB,
        8'h54,8'h7B,8'h94,8'h32,8'hA6,8'hC2,8'h23,8'h3D,8'hEE,8'h4C,8'h95,8'h0B,8'h42,8'hFA,8'hC3,8'h4E,
        8'h08,8'h2E,8'hA1,8'h66,8'h28,8'hD9,8'h24,8'hB2,8'h76,8'h5B,8'hA2,8'h49,8'h6D,8'h8B,8'hD1,8'h25,
        8'h72,8'hF8,8'hF6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hD4,8'hA4,8'h5C,8'hCC,8'h5D,8'h65,8'hB6,8'h92,
        8'h6C,8'h70,8'h48,8'h50,8'hFD,8'hED,8'hB9,8'hDA,8'h5E,8'h15,8'h46,8'h57,8'hA7,8'h8D,8'h9D,8'h84,
        8'h90,8'hD8,8'hAB,8'h00,8'h8C,8'hBC,8'hD3,8'h0A,8'hF7,8'hE4,8'h58,8'h05,8'hB8,8'hB3,8'h45,8'h06,
        8'hD0,8'h2C,8'h1E,8'h8F,8'hCA,8'h3F,8'h0F,8'h02,8'hC1,8'hAF,8'hBD,8'h03,8'h01,8'h13,8'h8A,8'h6B,
        8'h3A,8'h91,8'h11,8'h41,8'h4F,8'h67,8'hDC,8'hEA,8'h97,8'hF2,8'hCF,8'hCE,8'hF0,8'hB4,8'hE6,8'h73,
        8'h96,8'hAC,8'h74,8'h22,8'hE7,8'hAD,8'h35,8'h85,8'hE2,8'hF9,8'h37,8'hE8,8'h1C,8'h75,8'hDF,8'h6E,
        8'h47,8'hF1,8'h1A,8'h71,8'h1D,8'h29,8'hC5,8'h89,8'h6F,8'hB7,8'h62,8'h0E,8'hAA,8'h18,8'hBE,8'h1B,
        8'hFC,8'h56,8'h3E,8'h4B,8'hC6,8'hD2,8'h79,8'h20,8'h9A,8'hDB,8'hC0,8'hFE,8'h78,8'hCD,8'h5A,8'hF4,
        8'h1F,8'hDD,8'hA8,8'h33,8'h88,8'h07,8'hC7,8'h31,8'hB1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hEC,8'h5F,
        8'h60,8'h51,8'h7F,8'hA9,8'h19,8'hB5,8'h4A,8'h0D,8'h2D,8'hE5,8'h7A,8'h9F,8'h93,8'hC9,8'h9C,8'hEF,
        8'hA0,8'hE0,8'h3B,8'h4D,8'hAE,8'h2A,8'hF5,8'hB0,8'hC8,8'hEB,8'hBB,8'h3C,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2B,8'h04,8'h7E,8'hBA,8'h77,8'hD6,8'h26,8'hE1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0C,8'h7D
    };

    localparam logic [3:0] FWD_COEF [4] = '{4'h2, 4'h3, 4'h1, 4'h1};
    localparam logic [3:0] INV_COEF [4] = '{4'hE, 4'hB, 4'hD, 4'h9};

    // multiply by x in gf(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
    endfunction

    // multiply by a 4-bit constant
    function automatic logic [7:0] gmul4(input logic [7:0] a, input logic [3:0] c);
        logic [7:0] r;
        logic [7:0] p;
        r = 8'h00;
        p = a;
        for (int b = 0; b < 4; b++) begin
            if (c[b]) r = r ^ p;
            p = xtime(p);
        end
        return r;
    endfunction

    // one column of mixcolumns or its inverse, row 0 in the top byte
    function automatic logic [31:0] mix_col(input logic [31:0] w, input logic inv);
        logic [31:0] t;
        logic [7:0]  v;
        logic [3:0]  c;
        t = '0;
        for (int r = 0; r < 4; r++) begin
            v = 8'h00;
            for (int k = 0; k < 4; k++) begin
                c = inv ? INV_COEF[(k - r + 4) % 4] : FWD_COEF[(k - r + 4) % 4];
                v = v ^ gmul4(w[31 - 8*k -: 8], c);
            end
            t[31 - 8*r -: 8] = v;
        end
        return t;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // number of rounds, any other code as 256 bit
    function automatic logic [3:0] rounds_of(input logic [1:0] kl);
        logic [3:0] n;
        case (kl)
            KEYLEN_128: n = 4'd10;
            KEYLEN_192: n = 4'd12;
            default:    n = 4'd14;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/core/aes_ram.sv =====
// generic single write port ram with registered read
module aes_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/aes_lane.sv =====
// one byte lane: forward or inverse substitution
module aes_lane (
    input  logic       dec,
    input  logic [7:0] din,
    output logic [7:0] dout
);
    import aes_pkg::*;

    // table lookup per direction
    assign dout = dec ? INV_SBOX[din] : SBOX[din];

endmodule

// ===== rtl/core/aes_round.sv =====
// one full cipher round over sixteen byte lanes
module aes_round (
    input  logic         dec,
    input  logic         first,
    input  logic         last,
    input  logic [127:0] din,
    input  logic [127:0] round_key,
    output logic [127:0] dout
);
    import aes_pkg::*;

    logic [127:0] pre;
    logic [127:0] sub;
    logic [127:0] post;

    // inverse mix ahead of the lanes when decrypting, except in the first round
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            pre[127 - 32*c -: 32] = (dec && !first) ?
                mix_col(din[127 - 32*c -: 32], 1'b1) : din[127 - 32*c -: 32];
        end
    end

    // byte lanes with row shift folded into the source select
    for (genvar j = 0; j < 16; j++)
    begin : g_lane
        localparam int C     = j / 4;
        localparam int R     = j % 4;
        localparam int SRC_E = ((C + R) % 4) * 4 + R;
        localparam int SRC_D = ((C - R + 4) % 4) * 4 + R;
        logic [7:0] lane_in;
        assign lane_in = dec ? pre[127 - 8*SRC_D -: 8] : pre[127 - 8*SRC_E -: 8];
        aes_lane u_lane (
            .dec  (dec),
            .din  (lane_in),
            .dout (sub[127 - 8*j -: 8])
        );
    end

    // merge: forward mix per column when encrypting, except in the last round, then round key
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            post[127 - 32*c -: 32] = (!dec && !last) ?
                mix_col(sub[127 - 32*c -: 32], 1'b0) : sub[127 - 32*c -: 32];
        end
    end

    assign dout = post ^ round_key;

endmodule

// ===== rtl/core/aes_key_expand.sv =====
// key schedule, one word per cycle, written to the store a row at a time
module aes_key_expand (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [255:0]     key,
    input  logic [1:0]       key_length,
    output aes_pkg::ram_wr_t wr,
    output logic             done
);
    import aes_pkg::*;

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [2:0]  kc_reg, kc_next;
    logic [7:0]  rcon_reg, rcon_next;
    logic [31:0] win_reg [8];
    logic [95:0] row_reg;
    logic [3:0]  nk;
    logic [5:0]  last_idx;
    logic [31:0] t;
    logic [31:0] back;
    logic [31:0] word;

    // shape of the schedule
    always_comb
    begin
        case (key_length)
            KEYLEN_128: begin nk = 4'd4; back = win_reg[3]; end
            KEYLEN_192: begin nk = 4'd6; back = win_reg[5]; end
            default:    begin nk = 4'd8; back = win_reg[7]; end
        endcase
        last_idx = {rounds_of(key_length), 2'b11};
    end

    // next schedule word
    always_comb
    begin
        t         = win_reg[0];
        rcon_next = rcon_reg;
        if ({1'b0, kc_reg} == 4'd0)
        begin
            t         = sub_word({win_reg[0][23:0], win_reg[0][31:24]}) ^ {rcon_reg, 24'h0};
            rcon_next = xtime(rcon_reg);
        end
        else if (nk == 4'd8 && kc_reg == 3'd4)
        begin
            t = sub_word(win_reg[0]);
        end
        if (cnt_reg < {2'b00, nk})
        begin
            word      = key[255 - 32*cnt_reg[2:0] -: 32];
            rcon_next = rcon_reg;
        end
        else
        begin
            word = back ^ t;
        end
    end

    // counters
    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        kc_next   = kc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            kc_next   = '0;
        end
        else if (busy_reg)
        begin
            cnt_next  = cnt_reg + 6'd1;
            kc_next   = ({1'b0, kc_reg} == nk - 4'd1) ? 3'd0 : kc_reg + 3'd1;
            busy_next = (cnt_reg != last_idx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            kc_reg   <= '0;
            rcon_reg <= 8'h01;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            kc_reg   <= kc_next;
            rcon_reg <= start ? 8'h01 : (busy_reg ? rcon_next : rcon_reg);
        end
    end

    // word window and row gather
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            win_reg[0] <= word;
            for (int k = 1; k < 8; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
            row_reg <= {row_reg[63:0], word};
        end
    end

    assign wr.en   = busy_reg && (cnt_reg[1:0] == 2'b11);
    assign wr.addr = cnt_reg[5:2];
    assign wr.data = {row_reg, word};
    assign done    = busy_reg && (cnt_reg == last_idx);

endmodule

// ===== rtl/core/aes_block_cipher_ecb_cbc.sv =====
// top level: aes ecb and cbc with 128, 192 and 256 bit keys
// a block passes the init state, nr rounds and the finish state (nr = 10, 12 or 14)
// after a key or key length write the first block first waits for the key schedule
// a new block is taken only in idle, once the last has left the one round unit
// that every round of a block passes through, one round per cycle
// reset: config, chain value and key valid flag clear; round keys rebuilt on demand
`include "aes_block_cipher_ecb_cbc_assert.svh"
module aes_block_cipher_ecb_cbc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [3:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] block_high,
    input  logic [63:0] block_low,
    input  logic        first_block,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_high,
    output logic [63:0] result_low
);
    import aes_pkg::*;

    state_t       state_reg, state_next;
    logic [63:0]  key_reg [4];
    logic [63:0]  iv_high_reg, iv_low_reg;
    logic [1:0]   key_length_reg;
    logic [1:0]   mode_reg;
    logic         keys_valid_reg;
    logic [127:0] chain_reg;
    logic [127:0] data_reg;
    logic [127:0] blk_reg;
    logic [127:0] prev_reg;
    logic [127:0] st_reg, st_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic         out_valid_reg;
    logic [127:0] result_reg;
    logic         in_beat;
    logic         out_load;
    logic         ke_start;
    logic         ke_done;
    ram_wr_t      ke_wr;
    logic         cbc, dec;
    logic [3:0]   nr;
    logic [3:0]   rd_round;
    logic [3:0]   rd_clamp;
    logic [3:0]   rd_addr;
    logic [127:0] rk;
    logic [127:0] round_out;
    logic [127:0] in_blk;
    logic [127:0] chain_in;
    logic [127:0] final_blk;

    assign cbc      = mode_reg[0];
    assign dec      = mode_reg[1];
    assign nr       = rounds_of(key_length_reg);
    assign in_blk   = {block_high, block_low};
    assign chain_in = first_block ? {iv_high_reg, iv_low_reg} : chain_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = keys_valid_reg ? ST_INIT : ST_EXPAND;
            ST_EXPAND: if (ke_done) state_next = ST_KEYRD;
            ST_KEYRD:  state_next = ST_INIT;
            ST_INIT:   state_next = ST_ROUND;
            ST_ROUND:  if (rnd_reg == nr) state_next = ST_FINISH;
            ST_FINISH: if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_ready = 1'b0;
        out_load = 1'b0;
        ke_start = 1'b0;
        rd_round = rnd_reg + 4'd1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                ke_start = in_valid && !keys_valid_reg;
                rd_round = '0;
            end
            ST_KEYRD:  rd_round = '0;
            ST_FINISH: out_load = !out_valid_reg || out_ready;
            default:   ;
        endcase
    end

    assign in_beat = in_valid && in_ready;

    // key store row of the round fetched next
    assign rd_clamp = (rd_round > nr) ? nr : rd_round;
    assign rd_addr  = dec ? (nr - rd_clamp) : rd_clamp;

    aes_key_expand u_key (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (ke_start),
        .key        ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .key_length (key_length_reg),
        .wr         (ke_wr),
        .done       (ke_done)
    );

    aes_ram #(
        .WIDTH (128),
        .DEPTH (ROWS)
    ) u_store (
        .clk   (clk),
        .we    (ke_wr.en),
        .waddr (ke_wr.addr),
        .wdata (ke_wr.data),
        .raddr (rd_addr),
        .rdata (rk)
    );

    aes_round u_round (
        .dec       (dec),
        .first     (rnd_reg == 4'd1),
        .last      (rnd_reg == nr),
        .din       (st_reg),
        .round_key (rk),
        .dout      (round_out)
    );

    // round state
    always_comb
    begin
        st_next  = st_reg;
        rnd_next = rnd_reg;
        case (state_reg)
            ST_IDLE:  rnd_next = '0;
            ST_INIT:
            begin
                st_next  = data_reg ^ rk;
                rnd_next = 4'd1;
            end
            ST_ROUND:
            begin
                st_next  = round_out;
                rnd_next = (rnd_reg == nr) ? rnd_reg : rnd_reg + 4'd1;
            end
            default:  ;
        endcase
    end

    assign final_blk = (dec && cbc) ? (st_reg ^ prev_reg) : st_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rnd_reg        <= '0;
            out_valid_reg  <= 1'b0;
            keys_valid_reg <= 1'b0;
            chain_reg      <= '0;
            for (int k = 0; k < 4; k++)
            begin
                key_reg[k] <= '0;
            end
            iv_high_reg    <= '0;
            iv_low_reg     <= '0;
            key_length_reg <= KEYLEN_128;
            mode_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                chain_reg     <= dec ? blk_reg : st_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_EXPAND && ke_done)
            begin
                keys_valid_reg <= 1'b1;
            end
            // configuration writes
            if (cfg_write)
            begin
                unique case (cfg_index) inside
                    REG_KEY_0, REG_KEY_1, REG_KEY_2, REG_KEY_3:
                    begin
                        key_reg[cfg_index[1:0]] <= cfg_data;
                        keys_valid_reg          <= 1'b0;
                    end
                    REG_IV_HI:  iv_high_reg <= cfg_data;
                    REG_IV_LO:  iv_low_reg  <= cfg_data;
                    REG_KEYLEN:
                    begin
                        key_length_reg <= cfg_data[1:0];
                        keys_valid_reg <= 1'b0;
                    end
                    REG_MODE:   mode_reg <= cfg_data[1:0];
                    default:    ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            data_reg <= (cbc && !dec) ? (in_blk ^ chain_in) : in_blk;
            blk_reg  <= in_blk;
            prev_reg <= chain_in;
        end
        st_reg <= st_next;
        if (out_load)
        begin
            result_reg <= final_blk;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_high = result_reg[127:64];
    assign result_low  = result_reg[63:0];

    // checks
    `AES_ASSERT(a_round_range, clk, rst_n,
                (state_reg == ST_ROUND) |-> (rnd_reg >= 4'd1 && rnd_reg <= nr))
    `AES_ASSERT(a_keys_before_init, clk, rst_n, (state_reg == ST_INIT) |-> keys_valid_reg)
    `AES_ASSERT_NEVER(a_store_write_idle, clk, rst_n, ke_wr.en && state_reg != ST_EXPAND)
    `AES_ASSERT(a_expand_done, clk, rst_n, ke_done |-> (state_reg == ST_EXPAND))

endmodule
